// ===== rtl/b64e_pkg.sv =====
// Package with the shared types, constants and symbol function of the Base64 stream encoder.
package b64e_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned MaxChars = 5;
    localparam int unsigned IdxW     = 3;
    localparam int unsigned QDepth   = 2;
    localparam int unsigned QPtrW    = 1;
    localparam int unsigned QCntW    = 2;

    localparam logic [ByteW-1:0] ChPad      = 8'h3D;
    localparam logic [ByteW-1:0] ChNl       = 8'h0A;
    localparam logic [ByteW-1:0] LimitReset = 8'd76;

    localparam logic [IdxW-1:0] IdxGroup  = 3'd3;
    localparam logic [IdxW-1:0] IdxWithNl = 3'd4;

    localparam logic [1:0] PhaseEmpty = 2'd0;
    localparam logic [1:0] PhaseOne   = 2'd1;
    localparam logic [1:0] PhaseTwo   = 2'd2;

    typedef logic [ByteW-1:0] t_byte;

    typedef struct packed {
        t_byte [MaxChars-1:0] chars;
        logic [IdxW-1:0]      last_idx;
        logic                 eos;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_byte b64_sym(input logic [5:0] v);
        t_byte r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// Front part: register port, byte grouping, line counting and character job building.
module b64e_front import b64e_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_byte       i_data,
    input  logic        i_last,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_job        o_job
);

    logic [7:0]  r_limit;
    logic [15:0] r_held, n_held;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_line, n_line;
    logic        accept;
    logic        cfg_wr;
    logic [8:0]  sum;
    t_byte       b0, b1;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && !paddr[2];
    assign prdata  = paddr[2] ? 32'd0 : {24'd0, r_limit};
    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign b0      = r_held[15:8];
    assign b1      = r_held[7:0];
    assign sum     = {1'b0, r_line} + 9'd4;

    always_comb begin
        n_held  = r_held;
        n_phase = r_phase;
        n_line  = r_line;
        o_push  = 1'b0;
        o_job   = '0;
        if (r_phase == PhaseTwo) begin
            o_push          = accept;
            o_job.chars[0]  = b64_sym(b0[7:2]);
            o_job.chars[1]  = b64_sym({b0[1:0], b1[7:4]});
            o_job.chars[2]  = b64_sym({b1[3:0], i_data[7:6]});
            o_job.chars[3]  = b64_sym(i_data[5:0]);
            o_job.chars[4]  = ChNl;
            o_job.eos       = i_last;
            n_held          = '0;
            n_phase         = PhaseEmpty;
            if (sum >= {1'b0, r_limit}) begin
                o_job.last_idx = IdxWithNl;
                n_line         = '0;
            end else begin
                o_job.last_idx = IdxGroup;
                n_line         = sum[7:0];
            end
            if (i_last) begin
                n_line = '0;
            end
        end else if (!i_last) begin
            if (r_phase == PhaseOne) begin
                n_held  = {b0, i_data};
                n_phase = PhaseTwo;
            end else begin
                n_held  = {i_data, 8'd0};
                n_phase = PhaseOne;
            end
        end else begin
            o_push         = accept;
            o_job.last_idx = IdxWithNl;
            o_job.eos      = 1'b1;
            o_job.chars[4] = ChNl;
            if (r_phase == PhaseOne) begin
                o_job.chars[0] = b64_sym(b0[7:2]);
                o_job.chars[1] = b64_sym({b0[1:0], i_data[7:4]});
                o_job.chars[2] = b64_sym({i_data[3:0], 2'b00});
                o_job.chars[3] = ChPad;
            end else begin
                o_job.chars[0] = b64_sym(i_data[7:2]);
                o_job.chars[1] = b64_sym({i_data[1:0], 4'b0000});
                o_job.chars[2] = ChPad;
                o_job.chars[3] = ChPad;
            end
            n_held  = '0;
            n_phase = PhaseEmpty;
            n_line  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
            r_held  <= '0;
            r_phase <= PhaseEmpty;
            r_line  <= '0;
        end else begin
            if (cfg_wr) begin
                r_limit <= pwdata[7:0];
            end
            if (accept) begin
                r_held  <= n_held;
                r_phase <= n_phase;
                r_line  <= n_line;
            end
        end
    end

endmodule

// ===== rtl/b64e_queue.sv =====
// Two-entry job queue between the front and back parts.
module b64e_queue import b64e_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCntW-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_cnt == QCntW'(QDepth));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/b64e_back.sv =====
// Back part: walks the head job one character at a time into the output register.
module b64e_back import b64e_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_head,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_byte   o_char,
    output logic    o_eor,
    output logic    o_eos
);

    logic [IdxW-1:0] r_idx;
    logic            r_valid;
    t_byte           r_char;
    logic            r_eor, r_eos;
    logic            load, at_end;

    assign load    = !i_q_stat.empty && (!r_valid || i_ready);
    assign at_end  = (r_idx == i_head.last_idx);
    assign o_pop   = load && at_end;
    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_eor   = r_eor;
    assign o_eos   = r_eos;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_head.chars[r_idx];
            r_eor  <= at_end;
            r_eos  <= at_end && i_head.eos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? '0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_stat.empty |-> r_idx <= i_head.last_idx)
        else $error("character index beyond the end of the head job");

    a_job_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_stat.empty |-> (i_head.last_idx == IdxGroup || i_head.last_idx == IdxWithNl))
        else $error("head job has an impossible length");

    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_idx == '0)
        else $error("index not restarted after a job was finished");

    a_eos_on_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_eos |-> r_eor)
        else $error("stream end marked on an item that does not close its run");

endmodule

// ===== rtl/base64_stream_encoder_core.sv =====
// Top level of the streaming Base64 encoder with line breaking.
//  Channel | Direction | Payload
//  s_axis  | in        | tdata = data_byte, tlast = is_last
//  m_axis  | out       | tdata = out_char, tuser = end_of_run, tlast = end_of_stream
//  apb     | config    | line_limit at byte address 0
// A byte is taken whenever the queue is not full; each job of four or five characters
// drains at one per cycle while the output is taken. A job can wait in the queue while
// the output register holds an untaken item. Sustained throughput is set by the single
// character output port, so it depends on the line limit.
// Reset is synchronous and active low; it clears the group state, queue and output.
module base64_stream_encoder_core import b64e_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_char
    output logic [0:0]  m_axis_tuser,  // [0] end_of_run
    output logic        m_axis_tlast
);

    t_q_stat q_stat;
    t_job    push_job, head_job;
    logic    push, pop;
    logic    eor;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    b64e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_char   (m_axis_tdata),
        .o_eor    (eor),
        .o_eos    (m_axis_tlast)
    );

    assign m_axis_tuser = eor;

endmodule
